@@ design/resp_stream_parser_macros.svh @@
// Assertion macros used by the parser's top-level RTL file.
`ifndef RESP_STREAM_PARSER_MACROS_SVH
`define RESP_STREAM_PARSER_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define RSP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("resp parser check failed");

// Condition must never hold, checked out of reset.
`define RSP_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("resp parser check failed");

`endif

@@ design/rsp_pkg.sv @@
// Shared types, constants and codes of the RESP stream parser.
package rsp_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [30:0] OBJ_MAX = 31'h7FFF_FFFF;
	localparam logic [63:0] DEC_LIMIT = 64'd922337203685477580;

	localparam logic [20:0] MAX_LINE_RST = 21'd65536;
	localparam logic [30:0] MAX_BULK_RST = 31'd536870912;

	// Register indexes
	localparam logic REG_MAX_LINE = 1'b0;
	localparam logic REG_MAX_BULK = 1'b1;

	// Event codes
	localparam logic [3:0] EV_NONE = 4'd0;
	localparam logic [3:0] EV_SIMPLE = 4'd1;
	localparam logic [3:0] EV_ERRBYTE = 4'd2;
	localparam logic [3:0] EV_BULKBYTE = 4'd3;
	localparam logic [3:0] EV_STR_END = 4'd4;
	localparam logic [3:0] EV_INTEGER = 4'd5;
	localparam logic [3:0] EV_BULK_HDR = 4'd6;
	localparam logic [3:0] EV_ARRAY_HDR = 4'd7;
	localparam logic [3:0] EV_NIL = 4'd8;
	localparam logic [3:0] EV_ERROR = 4'd9;

	// Element kinds
	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_BULK = 2'd1;
	localparam logic [1:0] KIND_ARRAY = 2'd2;

	// Protocol characters
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		MODE_TYPE,
		MODE_LINE,
		MODE_NUMBER,
		MODE_BULK,
		MODE_BULK_END
	} mode_t;

	// Classified input byte
	typedef struct packed {
		logic [7:0] data;
		logic start_over;
		logic is_cr;
		logic is_lf;
		logic is_sign;
		logic is_minus;
		logic is_digit;
		logic [3:0] digit;
	} byte_info_t;

	// One result item
	typedef struct packed {
		logic [3:0] event_res;
		logic [7:0] data_byte;
		logic [63:0] number;
		logic [LVL_W-1:0] level;
		logic object_done;
		logic [30:0] object_bytes;
		logic last;
	} res_t;

	function automatic res_t mk_res(logic [3:0] ev, logic [7:0] d, logic [63:0] num,
		logic [LVL_W-1:0] lvl, logic done, logic [30:0] ob);
		res_t r;
		r.event_res = ev;
		r.data_byte = d;
		r.number = num;
		r.level = lvl;
		r.object_done = done;
		r.object_bytes = ob;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

@@ design/rsp_front.sv @@
// Front end: accepts stream bytes, classifies them and queues them for the parser core.
module rsp_front import rsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [7:0] byte_in,
	input  logic start_over,
	output logic item_valid,
	output byte_info_t item,
	input  logic item_take
);

	byte_info_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	byte_info_t cls;
	logic wr, rd;

	// Byte classification
	always_comb begin
		cls.data = byte_in;
		cls.start_over = start_over;
		cls.is_cr = (byte_in == CH_CR);
		cls.is_lf = (byte_in == CH_LF);
		cls.is_sign = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);
		cls.is_minus = (byte_in == CH_MINUS);
		cls.is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
		cls.digit = 4'(byte_in - CH_ZERO);
	end

	assign full = (cnt_q == 2'd2);
	assign wr = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign rd = item_take && item_valid;
	assign item = q_q[rp_q];

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
		end
	end

endmodule

@@ design/rsp_core.sv @@
// Parser core: runs the RESP state machine on one classified byte per cycle while the result queue has room.
module rsp_core import rsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [20:0] line_limit,
	input  logic [30:0] bulk_limit,
	input  logic item_valid,
	input  byte_info_t item,
	output logic item_take,
	input  logic room,
	output logic [1:0] res_cnt,
	output res_t res0,
	output res_t res1
);

	mode_t mode_q, mode_d;
	logic [30:0] stk_q [STACK_DEPTH];
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [63:0] nv_q, nv_d;
	logic neg_q, neg_d, dig_q, dig_d;
	logic [20:0] ll_q, ll_d;
	logic [30:0] br_q, br_d;
	logic [30:0] obc_q, obc_d;
	logic pcr_q, pcr_d;
	logic [1:0] kind_q, kind_d;
	logic err_q, err_d;

	logic stk_we;
	logic [STK_AW-1:0] stk_wi;
	logic [30:0] stk_wv;

	logic cx_found;
	logic [STK_AW-1:0] cx_idx;
	res_t rv [2];
	logic [1:0] n;
	logic [63:0] val, thr;
	logic [20:0] ll1;
	logic [32:0] obj_sum;
	logic ok;

	assign item_take = item_valid && room;

	// Innermost open array that survives an element completing
	always_comb begin
		cx_found = 1'b0;
		cx_idx = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if ((LVL_W'(i) < lvl_q) && (stk_q[i] != 31'd1)) begin
				cx_found = 1'b1;
				cx_idx = STK_AW'(i);
			end
		end
	end

	// Next state and results for the byte being taken
	always_comb begin
		mode_d = mode_q; lvl_d = lvl_q; nv_d = nv_q; neg_d = neg_q; dig_d = dig_q;
		ll_d = ll_q; br_d = br_q; obc_d = obc_q; pcr_d = pcr_q; kind_d = kind_q;
		err_d = err_q;
		stk_we = 1'b0; stk_wi = '0; stk_wv = '0;
		rv[0] = '0; rv[1] = '0; n = 2'd0;
		ok = 1'b1;
		ll1 = ll_q;
		val = neg_q ? 64'(-nv_q) : nv_q;
		thr = (neg_q ? (item.digit == 4'd9) : (item.digit >= 4'd8)) ? DEC_LIMIT - 64'd1
			: DEC_LIMIT;
		obj_sum = {2'b0, obc_q} + 33'd1 + {2'b0, nv_q[30:0]} + 33'd2;
		if (item_take) begin
			if (item.start_over) begin
				lvl_d = '0; obc_d = '0; err_d = 1'b0;
				mode_d = MODE_TYPE; nv_d = '0; neg_d = 1'b0; dig_d = 1'b0;
				ll_d = '0; br_d = '0; pcr_d = 1'b0; kind_d = KIND_SIMPLE;
			end else if (!err_q) begin
				if (obc_q == OBJ_MAX) begin
					err_d = 1'b1;
					rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_q); n = 2'd1;
				end else begin
					obc_d = obc_q + 31'd1;
					// complete() requested by flags below
					case (mode_q)
						MODE_LINE: begin
							if (pcr_q && item.is_lf) begin
								ok = 1'b0;
								rv[0] = mk_res(EV_STR_END, 8'd0, 64'(ll_q), lvl_q, 1'b0, obc_d);
								n = 2'd1;
								mode_d = MODE_TYPE; // completion handled below
							end else begin
								if (pcr_q) begin
									pcr_d = 1'b0;
									if (ll_q >= line_limit) begin
										ok = 1'b0; err_d = 1'b1;
										rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									end else begin
										ll1 = ll_q + 21'd1;
										rv[0] = mk_res((kind_q == KIND_SIMPLE) ? EV_SIMPLE : EV_ERRBYTE,
											CH_CR, 64'd0, lvl_q, 1'b0, obc_d);
									end
									n = 2'd1;
								end
								if (ok) begin
									if (item.is_cr) begin
										pcr_d = 1'b1;
									end else if (ll1 >= line_limit) begin
										err_d = 1'b1;
										rv[n[0]] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
										n = 2'(n + 2'd1);
									end else begin
										ll1 = ll1 + 21'd1;
										rv[n[0]] = mk_res((kind_q == KIND_SIMPLE) ? EV_SIMPLE : EV_ERRBYTE,
											item.data, 64'd0, lvl_q, 1'b0, obc_d);
										n = 2'(n + 2'd1);
									end
								end
								ll_d = ll1;
							end
						end
						MODE_NUMBER: begin
							if (pcr_q) begin
								if (!item.is_lf) begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								end else if (kind_q == KIND_SIMPLE) begin
									rv[0] = mk_res(EV_INTEGER, 8'd0, val, lvl_q, 1'b0, obc_d);
									ok = 1'b0;
								end else if (neg_q && nv_q == 64'd1) begin
									rv[0] = mk_res(EV_NIL, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									ok = 1'b0;
								end else if (neg_q && nv_q != 64'd0) begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								end else if (kind_q == KIND_BULK) begin
									if ((|nv_q[63:31]) || (nv_q[30:0] > bulk_limit)
										|| (obj_sum > {2'b0, OBJ_MAX})) begin
										err_d = 1'b1;
										rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									end else begin
										rv[0] = mk_res(EV_BULK_HDR, 8'd0, nv_q, lvl_q, 1'b0, obc_d);
										br_d = nv_q[30:0];
										pcr_d = 1'b0;
										mode_d = (nv_q == 64'd0) ? MODE_BULK_END : MODE_BULK;
									end
								end else if (|nv_q[63:31]) begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								end else if (nv_q == 64'd0) begin
									rv[0] = mk_res(EV_ARRAY_HDR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									ok = 1'b0;
								end else if (lvl_q >= LVL_W'(STACK_DEPTH)) begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								end else begin
									rv[0] = mk_res(EV_ARRAY_HDR, 8'd0, nv_q, lvl_q, 1'b0, obc_d);
									stk_we = 1'b1;
									stk_wi = STK_AW'(lvl_q);
									stk_wv = nv_q[30:0];
									lvl_d = lvl_q + LVL_W'(1);
									mode_d = MODE_TYPE; nv_d = '0; neg_d = 1'b0; dig_d = 1'b0;
									ll_d = '0; br_d = '0; pcr_d = 1'b0; kind_d = KIND_SIMPLE;
								end
								n = 2'd1;
							end else if (item.is_cr) begin
								if (dig_q) begin
									pcr_d = 1'b1;
								end else begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									n = 2'd1;
								end
							end else if (ll_q >= line_limit) begin
								err_d = 1'b1;
								rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								n = 2'd1;
							end else begin
								ll_d = ll_q + 21'd1;
								if (item.is_sign && ll_q == 21'd0) begin
									if (item.is_minus) begin
										neg_d = 1'b1;
									end
								end else if (item.is_digit) begin
									if (nv_q > thr) begin
										err_d = 1'b1;
										rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
										n = 2'd1;
									end else begin
										nv_d = (nv_q << 3) + (nv_q << 1) + 64'(item.digit);
										dig_d = 1'b1;
									end
								end else begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									n = 2'd1;
								end
							end
						end
						MODE_BULK: begin
							rv[0] = mk_res(EV_BULKBYTE, item.data, 64'd0, lvl_q, 1'b0, obc_d);
							n = 2'd1;
							br_d = br_q - 31'd1;
							if (br_q == 31'd1) begin
								mode_d = MODE_BULK_END;
								pcr_d = 1'b0;
							end
						end
						MODE_BULK_END: begin
							if (!pcr_q) begin
								if (item.is_cr) begin
									pcr_d = 1'b1;
								end else begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									n = 2'd1;
								end
							end else if (item.is_lf) begin
								rv[0] = mk_res(EV_STR_END, 8'd0, nv_q, lvl_q, 1'b0, obc_d);
								n = 2'd1;
								ok = 1'b0;
							end else begin
								err_d = 1'b1;
								rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
								n = 2'd1;
							end
						end
						default: begin
							mode_d = MODE_TYPE; nv_d = '0; neg_d = 1'b0; dig_d = 1'b0;
							ll_d = '0; br_d = '0; pcr_d = 1'b0; kind_d = KIND_SIMPLE;
							case (item.data)
								CH_PLUS: begin mode_d = MODE_LINE; kind_d = KIND_SIMPLE; end
								CH_MINUS: begin mode_d = MODE_LINE; kind_d = KIND_BULK; end
								CH_COLON: begin mode_d = MODE_NUMBER; kind_d = KIND_SIMPLE; end
								CH_DOLLAR: begin mode_d = MODE_NUMBER; kind_d = KIND_BULK; end
								CH_STAR: begin mode_d = MODE_NUMBER; kind_d = KIND_ARRAY; end
								default: begin
									err_d = 1'b1;
									rv[0] = mk_res(EV_ERROR, 8'd0, 64'd0, lvl_q, 1'b0, obc_d);
									n = 2'd1;
								end
							endcase
						end
					endcase
					// Element completion: close finished arrays, flag object end
					if (!ok && !err_d) begin
						if (cx_found) begin
							stk_we = 1'b1;
							stk_wi = cx_idx;
							stk_wv = stk_q[cx_idx] - 31'd1;
							lvl_d = LVL_W'(cx_idx) + LVL_W'(1);
						end else begin
							lvl_d = '0;
							obc_d = '0;
						end
						rv[0].object_done = !cx_found;
						mode_d = MODE_TYPE; nv_d = '0; neg_d = 1'b0; dig_d = 1'b0;
						ll_d = '0; br_d = '0; pcr_d = 1'b0; kind_d = KIND_SIMPLE;
					end
				end
			end
		end
		if (n == 2'd2) begin
			rv[1].last = 1'b1;
		end else if (n == 2'd1) begin
			rv[0].last = 1'b1;
		end
	end

	assign res_cnt = n;
	assign res0 = rv[0];
	assign res1 = rv[1];

	// Array count stack
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_q[stk_wi] <= stk_wv;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TYPE;
			lvl_q <= '0;
			nv_q <= '0;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
			ll_q <= '0;
			br_q <= '0;
			obc_q <= '0;
			pcr_q <= 1'b0;
			kind_q <= KIND_SIMPLE;
			err_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			lvl_q <= lvl_d;
			nv_q <= nv_d;
			neg_q <= neg_d;
			dig_q <= dig_d;
			ll_q <= ll_d;
			br_q <= br_d;
			obc_q <= obc_d;
			pcr_q <= pcr_d;
			kind_q <= kind_d;
			err_q <= err_d;
		end
	end

endmodule

@@ design/rsp_outq.sv @@
// Result queue: takes up to two results per cycle, hands out one per transfer.
module rsp_outq import rsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [1:0] wr_cnt,
	input  res_t wr0,
	input  res_t wr1,
	output logic room,
	output logic empty,
	input  logic pop,
	output res_t head
);

	res_t q_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic rd;

	assign room = (cnt_q <= 3'd2);
	assign empty = (cnt_q == 3'd0);
	assign rd = pop && !empty;
	assign head = q_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			q_q[wp_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			q_q[2'(wp_q + 2'd1)] <= wr1;
		end
	end

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= 2'(wp_q + wr_cnt);
			if (rd) begin
				rp_q <= 2'(rp_q + 2'd1);
			end
			cnt_q <= 3'(cnt_q + {1'b0, wr_cnt} - {2'b0, rd});
		end
	end

endmodule

@@ design/resp_stream_parser.sv @@
// Top level of the RESP byte stream parser.
// Bytes enter through push/full and are parsed at one byte per cycle while the result queue
// has room; each byte yields zero, one or two result events, read out through empty/pop. A
// two-entry byte queue feeds the parser core, and a four-entry result queue behind it lets
// the core take a byte whenever at least two result slots are free. A pushed byte is
// registered in the byte queue and its events in the result queue, which drives the result
// ports. A byte that yields two events needs two pops, so the byte rate follows the rate at
// which results are drained. start_over clears the parser and its error latch. The line
// length limit (address 0) and the bulk length limit (address 4) are set through the APB port;
// the user must write them only while the parser is idle, as the block does not enforce this.
module resp_stream_parser import rsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic [7:0] byte_in,
	input  logic start_over,
	output logic empty,
	input  logic pop,
	output logic [3:0] event_res,
	output logic [7:0] data_byte,
	output logic signed [63:0] number,
	output logic [3:0] level,
	output logic object_done,
	output logic [30:0] object_bytes,
	output logic last
);

	`include "resp_stream_parser_macros.svh"

	logic [20:0] max_line_q;
	logic [30:0] max_bulk_q;
	logic item_valid, item_take, room;
	byte_info_t item;
	logic [1:0] res_cnt;
	res_t res0, res1, head;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= MAX_LINE_RST;
			max_bulk_q <= MAX_BULK_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MAX_LINE) begin
				max_line_q <= pwdata[20:0];
			end else begin
				max_bulk_q <= pwdata[30:0];
			end
		end
	end
	assign prdata = (paddr[2] == REG_MAX_BULK) ? {1'b0, max_bulk_q} : {11'd0, max_line_q};

	rsp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .byte_in(byte_in),
		.start_over(start_over), .item_valid(item_valid), .item(item), .item_take(item_take)
	);

	rsp_core u_core (
		.clk(clk), .arst_n(arst_n), .line_limit(max_line_q), .bulk_limit(max_bulk_q),
		.item_valid(item_valid), .item(item), .item_take(item_take), .room(room),
		.res_cnt(res_cnt), .res0(res0), .res1(res1)
	);

	rsp_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr_cnt(res_cnt), .wr0(res0), .wr1(res1),
		.room(room), .empty(empty), .pop(pop), .head(head)
	);

	assign event_res = head.event_res;
	assign data_byte = head.data_byte;
	assign number = head.number;
	assign level = 4'(head.level);
	assign object_done = head.object_done;
	assign object_bytes = head.object_bytes;
	assign last = head.last;

	`RSP_ASSERT_IMPLIES(a_ev_range, clk, arst_n, !empty, event_res >= EV_SIMPLE && event_res <= EV_ERROR)
	`RSP_ASSERT_IMPLIES(a_done_last, clk, arst_n, !empty && object_done, last)
	`RSP_ASSERT_NEVER(a_take_no_room, clk, arst_n, item_take && !room)

endmodule

@@ tb/sv/resp_stream_parser_tb.sv @@
// Self-checking testbench for the RESP stream parser: directed and random byte streams.
`timescale 1ns / 100ps

module resp_stream_parser_tb;
	import rsp_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;

	// Parser predictor and store of expected events
	class resp_scoreboard;
		logic [20:0] line_max;
		logic [30:0] bulk_max;
		mode_t mode;
		logic [30:0] counts [STACK_DEPTH];
		int nest;
		logic [63:0] num_val;
		bit num_digit, num_neg;
		logic [20:0] line_len;
		logic [30:0] bulk_left;
		logic [30:0] obj_cnt;
		bit cr_seen;
		logic [1:0] kind;
		bit err_latch;
		res_t step_res[$];
		res_t expected_events[$];
		int mismatches, objects_done, errors_seen, events_checked;

		function new();
			line_max = MAX_LINE_RST;
			bulk_max = MAX_BULK_RST;
			mismatches = 0;
			objects_done = 0;
			errors_seen = 0;
			events_checked = 0;
			clear_all();
		endfunction

		function void clear_element();
			mode = MODE_TYPE;
			num_val = '0;
			num_digit = 0;
			num_neg = 0;
			line_len = '0;
			bulk_left = '0;
			cr_seen = 0;
			kind = KIND_SIMPLE;
		endfunction

		function void clear_all();
			foreach (counts[i]) counts[i] = '0;
			nest = 0;
			obj_cnt = '0;
			err_latch = 0;
			clear_element();
		endfunction

		function void emit(logic [3:0] ev, logic [7:0] d, logic [63:0] num, int lvl, bit done);
			res_t r;
			if (step_res.size() >= 2) return;
			r.event_res = ev;
			r.data_byte = d;
			r.number = num;
			r.level = lvl[3:0];
			r.object_done = done;
			r.object_bytes = obj_cnt;
			r.last = 1'b0;
			step_res.push_back(r);
		endfunction

		function void raise_error();
			err_latch = 1;
			emit(EV_ERROR, 8'h00, 64'd0, nest, 0);
		endfunction

		// Finish an element and close every array it completes
		function void finish_element(logic [3:0] ev, logic [63:0] num);
			int lvl;
			bit done;
			lvl = nest;
			while (nest > 0 && nest <= STACK_DEPTH) begin
				counts[nest-1] = (counts[nest-1] - 31'd1) & OBJ_MAX;
				if (counts[nest-1] != 0) break;
				nest--;
			end
			done = (nest == 0);
			emit(ev, 8'h00, num, lvl, done);
			if (done) obj_cnt = '0;
			clear_element();
		endfunction

		function bit line_commit(logic [7:0] c);
			if (line_len >= line_max) begin
				raise_error();
				return 0;
			end
			line_len++;
			emit((kind == KIND_SIMPLE) ? EV_SIMPLE : EV_ERRBYTE, c, 64'd0, nest, 0);
			return 1;
		endfunction

		function void line_byte(logic [7:0] b);
			if (cr_seen) begin
				if (b == CH_LF) begin
					finish_element(EV_STR_END, {43'd0, line_len});
					return;
				end
				cr_seen = 0;
				if (!line_commit(CH_CR)) return;
			end
			if (b == CH_CR) cr_seen = 1;
			else void'(line_commit(b));
		endfunction

		function void number_end();
			logic [63:0] val;
			val = num_neg ? (64'd0 - num_val) : num_val;
			if (kind == KIND_SIMPLE) begin
				finish_element(EV_INTEGER, val);
				return;
			end
			if (num_neg && num_val == 64'd1) begin
				finish_element(EV_NIL, 64'd0);
				return;
			end
			if (num_neg && num_val != 0) begin
				raise_error();
				return;
			end
			if (kind == KIND_BULK) begin
				if (num_val > {33'd0, bulk_max} ||
						{33'd0, obj_cnt} + num_val + 64'd2 > {33'd0, OBJ_MAX}) begin
					raise_error();
					return;
				end
				emit(EV_BULK_HDR, 8'h00, num_val, nest, 0);
				bulk_left = num_val[30:0];
				cr_seen = 0;
				mode = (num_val == 0) ? MODE_BULK_END : MODE_BULK;
				return;
			end
			if (num_val > {33'd0, OBJ_MAX}) begin
				raise_error();
				return;
			end
			if (num_val == 0) begin
				finish_element(EV_ARRAY_HDR, 64'd0);
				return;
			end
			if (nest >= STACK_DEPTH) begin
				raise_error();
				return;
			end
			emit(EV_ARRAY_HDR, 8'h00, num_val, nest, 0);
			counts[nest] = num_val[30:0];
			nest++;
			clear_element();
		endfunction

		function void number_byte(logic [7:0] b);
			logic [63:0] d, lim;
			if (cr_seen) begin
				if (b == CH_LF) number_end();
				else raise_error();
				return;
			end
			if (b == CH_CR) begin
				if (num_digit) cr_seen = 1;
				else raise_error();
				return;
			end
			if (line_len >= line_max) begin
				raise_error();
				return;
			end
			line_len++;
			if ((b == CH_PLUS || b == CH_MINUS) && line_len == 1) begin
				if (b == CH_MINUS) num_neg = 1;
				return;
			end
			if (b >= CH_ZERO && b <= CH_NINE) begin
				d = {56'd0, b - CH_ZERO};
				lim = num_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				if (num_val > (lim - d) / 64'd10) begin
					raise_error();
					return;
				end
				num_val = num_val * 64'd10 + d;
				num_digit = 1;
				return;
			end
			raise_error();
		endfunction

		function void type_byte(logic [7:0] b);
			clear_element();
			case (b)
				CH_PLUS: begin mode = MODE_LINE; kind = KIND_SIMPLE; end
				CH_MINUS: begin mode = MODE_LINE; kind = KIND_BULK; end
				CH_COLON: begin mode = MODE_NUMBER; kind = KIND_SIMPLE; end
				CH_DOLLAR: begin mode = MODE_NUMBER; kind = KIND_BULK; end
				CH_STAR: begin mode = MODE_NUMBER; kind = KIND_ARRAY; end
				default: raise_error();
			endcase
		endfunction

		// Accepted input transfer: predict its events
		function void note_byte(logic [7:0] b, bit so);
			step_res.delete();
			if (so) begin
				clear_all();
				return;
			end
			if (err_latch) return;
			if (obj_cnt >= OBJ_MAX) raise_error();
			else begin
				obj_cnt++;
				case (mode)
					MODE_LINE: line_byte(b);
					MODE_NUMBER: number_byte(b);
					MODE_BULK: begin
						emit(EV_BULKBYTE, b, 64'd0, nest, 0);
						bulk_left = (bulk_left - 31'd1) & OBJ_MAX;
						if (bulk_left == 0) begin
							mode = MODE_BULK_END;
							cr_seen = 0;
						end
					end
					MODE_BULK_END: begin
						if (!cr_seen) begin
							if (b == CH_CR) cr_seen = 1;
							else raise_error();
						end else if (b == CH_LF) finish_element(EV_STR_END, num_val);
						else raise_error();
					end
					default: type_byte(b);
				endcase
			end
			if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
			foreach (step_res[i]) expected_events.push_back(step_res[i]);
		endfunction

		// Accepted result transfer: compare with the oldest expected event
		function void check(res_t got);
			res_t exp_r;
			events_checked++;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH: unexpected event ev=%0d data=%02h num=%0d",
						got.event_res, got.data_byte, $signed(got.number));
				return;
			end
			exp_r = expected_events.pop_front();
			if (got.event_res === EV_ERROR) errors_seen++;
			if (got.object_done === 1'b1) objects_done++;
			if (got.event_res !== exp_r.event_res || got.data_byte !== exp_r.data_byte ||
					got.number !== exp_r.number || got.level !== exp_r.level ||
					got.object_done !== exp_r.object_done ||
					got.object_bytes !== exp_r.object_bytes || got.last !== exp_r.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("MISMATCH exp: ev=%0d d=%02h n=%0d lvl=%0d done=%0b ob=%0d last=%0b",
						exp_r.event_res, exp_r.data_byte, $signed(exp_r.number), exp_r.level,
						exp_r.object_done, exp_r.object_bytes, exp_r.last);
					$display("         got: ev=%0d d=%02h n=%0d lvl=%0d done=%0b ob=%0d last=%0b",
						got.event_res, got.data_byte, $signed(got.number), got.level,
						got.object_done, got.object_bytes, got.last);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic push, full, start_over, empty, pop;
	logic [7:0] byte_in;
	logic [3:0] event_res;
	logic [7:0] data_byte;
	logic signed [63:0] number;
	logic [3:0] level;
	logic object_done;
	logic [30:0] object_bytes;
	logic last;

	resp_scoreboard sb;
	logic [7:0] byte_q[$];
	bit quiet;
	int pop_hold, idle_cycles, bytes_sent;
	res_t mon_r;

	resp_stream_parser uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Result side: check transfers and stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				mon_r.event_res = event_res;
				mon_r.data_byte = data_byte;
				mon_r.number = number;
				mon_r.level = level;
				mon_r.object_done = object_done;
				mon_r.object_bytes = object_bytes;
				mon_r.last = last;
				sb.check(mon_r);
			end
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				pop_hold = $urandom_range(0, 6);
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// One input transfer, then maybe a random gap
	task automatic send(logic [7:0] b, bit so);
		push <= 1'b1;
		byte_in <= b;
		start_over <= so;
		do @(posedge clk); while (full);
		sb.note_byte(b, so);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) send(s[i], 0);
	endtask

	task automatic clear_parser();
		send(8'($urandom_range(0, 255)), 1);
	endtask

	task automatic flush_queue();
		while (byte_q.size() > 0) send(byte_q.pop_front(), 0);
	endtask

	// Drain all events and let the pipe settle
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.expected_events.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MAX_LINE) sb.line_max = val[20:0];
		else sb.bulk_max = val[30:0];
	endtask

	task automatic set_limits(logic [31:0] line_v, logic [31:0] bulk_v);
		wait_idle();
		write_reg(REG_MAX_LINE, line_v);
		write_reg(REG_MAX_BULK, bulk_v);
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
	endtask

	// Line content byte: anything but CR/LF, sometimes a lone CR
	task automatic add_line_content(int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				byte_q.push_back(CH_CR);
				byte_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
			end else begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_CR || c == CH_LF) c = 8'h7E;
				byte_q.push_back(c);
			end
		end
	endtask

	task automatic add_number(byte unsigned lead);
		longint v;
		byte_q.push_back(lead);
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = -longint'($urandom_range(0, 1000));
			default: v = $urandom_range(0, 100000);
		endcase
		if ($urandom_range(0, 7) == 0) byte_q.push_back(CH_PLUS);
		add_str($sformatf("%0d\r\n", v));
	endtask

	// Object with random content, mostly well-formed
	task automatic add_object(int depth);
		int n;
		case ($urandom_range(0, (depth < 9) ? 7 : 5))
			0: begin byte_q.push_back(CH_PLUS); add_line_content($urandom_range(0, 8));
				add_str("\r\n"); end
			1: begin byte_q.push_back(CH_MINUS); add_line_content($urandom_range(0, 8));
				add_str("\r\n"); end
			2: add_number(CH_COLON);
			3, 4: begin
				n = $urandom_range(0, 10);
				add_str($sformatf("$%0d\r\n", n));
				for (int i = 0; i < n; i++) byte_q.push_back(8'($urandom_range(0, 255)));
				add_str("\r\n");
			end
			5: add_str(($urandom_range(0, 1) != 0) ? "$-1\r\n" : "*-1\r\n");
			default: begin
				n = $urandom_range(0, 3);
				add_str($sformatf("*%0d\r\n", n));
				for (int i = 0; i < n; i++) add_object(depth + 1);
			end
		endcase
	endtask

	task automatic random_phase(int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			add_object(0);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 9) == 0)
				void'(byte_q.pop_back());
			flush_queue();
			if ($urandom_range(0, 3) == 0) clear_parser();
		end
		clear_parser();
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		push = 0; byte_in = '0; start_over = 0; pop = 0;
		quiet = 0; pop_hold = 0; idle_cycles = 0; bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every type, and error paths
		send_str("+OK\r\n-ERR a\rb\r\n:0\r\n:-9223372036854775808\r\n");
		send_str(":9223372036854775807\r\n$3\r\nabc\r\n$0\r\n\r\n$-1\r\n*-1\r\n*0\r\n");
		send_str("*2\r\n:1\r\n*1\r\n+x\r\n");
		send_str(":9223372036854775808\r\n"); clear_parser();
		send_str(":-9223372036854775809\r\n"); clear_parser();
		send_str(":\r\n"); clear_parser();
		send_str(":12\rx"); clear_parser();
		send_str(":1-2\r\n"); clear_parser();
		send_str("$-2\r\n"); clear_parser();
		send_str("*-5\r\n"); clear_parser();
		send_str("$600000000\r\n"); clear_parser();
		send_str("*2147483648\r\n"); clear_parser();
		send_str("$1\r\nab"); clear_parser();
		send_str("$1\r\na\rx"); clear_parser();
		send(8'hFF, 0); send(8'h00, 0); clear_parser();
		for (int i = 0; i < 9; i++) send_str("*1\r\n");
		clear_parser();

		random_phase(300);
		set_limits(32'd1, 32'd0);
		send_str("+ab\r\n"); clear_parser();
		send_str("$1\r\n"); clear_parser();
		random_phase(200);
		set_limits(32'd1048576, 32'd2147483647);
		send_str("$2147483646\r\n"); clear_parser();
		random_phase(300);
		set_limits(32'd6, 32'd5);
		random_phase(250);
		set_limits($urandom_range(16, 64), $urandom_range(0, 20));
		random_phase(150);
		quiet = 1;
		random_phase(200);

		wait_idle();
		$display("Summary: %0d input bytes, %0d events checked, %0d objects completed",
			bytes_sent, sb.events_checked, sb.objects_done);
		$display("Summary: %0d protocol errors seen over five limit settings, %0d mismatches",
			sb.errors_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_events.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/rsp_pkg.sv
design/rsp_front.sv
design/rsp_core.sv
design/rsp_outq.sv
design/resp_stream_parser.sv
tb/sv/resp_stream_parser_tb.sv
